>>> src/mmt_pkg.sv
// Shared types and constants for the matrix multiply block.
`default_nettype none
package mmt_pkg;
	localparam int MAX_DIM_DEF = 8;
	localparam int DIM_W = 4;
	localparam int IDX_W = 6;
	localparam int VAL_W = 32;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		REQ_LOAD_A = 2'd0,
		REQ_LOAD_B = 2'd1,
		REQ_START  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_A_ROWS  = 3'd0,
		CFG_A_COLS  = 3'd1,
		CFG_B_ROWS  = 3'd2,
		CFG_B_COLS  = 3'd3,
		CFG_TRANS_A = 3'd4,
		CFG_TRANS_B = 3'd5,
		CFG_C_ROWS  = 3'd6,
		CFG_C_COLS  = 3'd7
	} cfg_idx_t;

	// decoded start command handed from front to back
	typedef struct packed {
		logic       err;
		logic [2:0] lrows_m1;
		logic [2:0] lcols_m1;
		logic [2:0] rcols_m1;
		logic [3:0] a_rows;
		logic [3:0] b_rows;
		logic       trans_a;
		logic       trans_b;
	} cmd_t;
endpackage
`default_nettype wire

>>> src/mmt_front.sv
// Front end: configuration registers, operand stores, start classification.
`default_nettype none
module mmt_front import mmt_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [DIM_W-1:0]    cfg_data,
	input  wire logic                valid,
	output logic                     ready,
	input  wire logic [1:0]          req_type,
	input  wire logic [IDX_W-1:0]    elem_index,
	input  wire logic signed [VAL_W-1:0] elem_value,
	output logic                     cmd_valid,
	input  wire logic                cmd_ready,
	output cmd_t                     cmd,
	// store read ports used by the back end
	input  wire logic [IDX_W-1:0]    a_raddr,
	input  wire logic [IDX_W-1:0]    b_raddr,
	output logic signed [VAL_W-1:0]  a_rdata,
	output logic signed [VAL_W-1:0]  b_rdata
);
	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q, c_rows_q, c_cols_q;
	logic             trans_a_q, trans_b_q;
	logic signed [VAL_W-1:0] a_mem [DEPTH];
	logic signed [VAL_W-1:0] b_mem [DEPTH];
	logic             busy_q;
	logic             acc, idx_ok;
	logic [DIM_W-1:0] lrows, lcols, rrows, rcols;
	logic             dims_ok;
	cmd_t             cmd_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_W'(1); a_cols_q <= DIM_W'(1);
			b_rows_q <= DIM_W'(1); b_cols_q <= DIM_W'(1);
			c_rows_q <= DIM_W'(1); c_cols_q <= DIM_W'(1);
			trans_a_q <= 1'b0; trans_b_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_A_ROWS:  a_rows_q <= cfg_data;
				CFG_A_COLS:  a_cols_q <= cfg_data;
				CFG_B_ROWS:  b_rows_q <= cfg_data;
				CFG_B_COLS:  b_cols_q <= cfg_data;
				CFG_TRANS_A: trans_a_q <= cfg_data[0];
				CFG_TRANS_B: trans_b_q <= cfg_data[0];
				CFG_C_ROWS:  c_rows_q <= cfg_data;
				CFG_C_COLS:  c_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a start waits in busy_q until the back end takes it; input then stays
	// stalled until the back end is idle, so the stores hold still under it
	assign ready = !busy_q && cmd_ready;
	assign acc   = valid && ready;
	assign idx_ok = {1'b0, elem_index} < (IDX_W+1)'(DEPTH);

	always_ff @(posedge clk) begin
		if (acc && idx_ok && req_type == REQ_LOAD_A)
			a_mem[elem_index[$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]] <= elem_value;
		if (acc && idx_ok && req_type == REQ_LOAD_B)
			b_mem[elem_index[$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]] <= elem_value;
		a_rdata <= a_mem[a_raddr[$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]];
		b_rdata <= b_mem[b_raddr[$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]];
	end

	function automatic logic dim_ok(input logic [DIM_W-1:0] d);
		dim_ok = d != '0 && d <= DIM_W'(MAX_DIM);
	endfunction

	always_comb begin
		lrows = trans_a_q ? a_cols_q : a_rows_q;
		lcols = trans_a_q ? a_rows_q : a_cols_q;
		rrows = trans_b_q ? b_cols_q : b_rows_q;
		rcols = trans_b_q ? b_rows_q : b_cols_q;
		dims_ok = dim_ok(a_rows_q) && dim_ok(a_cols_q) && dim_ok(b_rows_q) &&
			dim_ok(b_cols_q) && dim_ok(c_rows_q) && dim_ok(c_cols_q);
		cmd_n.err = !dims_ok || lcols != rrows || c_rows_q != lrows || c_cols_q != rcols;
		cmd_n.lrows_m1 = 3'(lrows - 1'b1);
		cmd_n.lcols_m1 = 3'(lcols - 1'b1);
		cmd_n.rcols_m1 = 3'(rcols - 1'b1);
		cmd_n.a_rows = a_rows_q;
		cmd_n.b_rows = b_rows_q;
		cmd_n.trans_a = trans_a_q;
		cmd_n.trans_b = trans_b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (acc && req_type == REQ_START) begin
			busy_q <= 1'b1;
		end else if (cmd_ready) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && req_type == REQ_START) cmd <= cmd_n;
	end

	assign cmd_valid = busy_q;
endmodule
`default_nettype wire

>>> src/mmt_back.sv
// Back end: dot-product sequencer, one multiply-accumulate per cycle while in ST_RUN.
`default_nettype none
module mmt_back import mmt_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_ready,
	input  wire cmd_t                cmd,
	output logic [IDX_W-1:0]         a_raddr,
	output logic [IDX_W-1:0]         b_raddr,
	input  wire logic signed [VAL_W-1:0] a_rdata,
	input  wire logic signed [VAL_W-1:0] b_rdata,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [VAL_W-1:0]  product_value,
	output logic [2:0]               out_row,
	output logic [2:0]               out_col,
	output logic                     last,
	output logic                     status
);
	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_OUT} st_t;
	st_t st_q, st_n;
	cmd_t cmd_q;
	logic [2:0] i_q, j_q, k_q;
	// read pipeline: address issued, data back in the next cycle, product in the cycle after that
	logic       v_s1, v_s2, lastk_s1, lastk_s2;
	logic signed [63:0] prod_s2, acc_q, sum;
	logic [6:0] ai, bi;
	logic       k_end;
	logic signed [VAL_W-1:0] res;
	logic signed [47:0] q;

	assign k_end = k_q == cmd_q.lcols_m1;

	always_comb begin
		ai = cmd_q.trans_a ? 7'(i_q * cmd_q.a_rows + k_q) : 7'(k_q * cmd_q.a_rows + i_q);
		bi = cmd_q.trans_b ? 7'(k_q * cmd_q.b_rows + j_q) : 7'(j_q * cmd_q.b_rows + k_q);
		a_raddr = ai[IDX_W-1:0];
		b_raddr = bi[IDX_W-1:0];
	end

	// saturating 64-bit add; the sum then drops its low 16 bits and saturates to 32 bits
	always_comb begin
		sum = acc_q + prod_s2;
		if (!acc_q[63] && !prod_s2[63] && sum[63]) sum = {1'b0, {63{1'b1}}};
		else if (acc_q[63] && prod_s2[63] && !sum[63]) sum = {1'b1, 63'd0};
		q = sum[63:16];
		if (q > 48'sh7FFFFFFF) res = 32'sh7FFFFFFF;
		else if (q < -48'sh80000000) res = -32'sh80000000;
		else res = q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_n;
	end

	always_comb begin
		st_n = st_q;
		cmd_ready = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) st_n = cmd.err ? ST_OUT : ST_RUN;
			end
			ST_RUN:   if (k_end) st_n = ST_DRAIN;
			ST_DRAIN: if (v_s2 && lastk_s2) st_n = ST_OUT;
			ST_OUT: begin
				if (out_ready)
					st_n = last ? ST_IDLE : ST_RUN;
			end
			default: st_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0;
		end else begin
			v_s1 <= st_q == ST_RUN;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		lastk_s1 <= k_end;
		lastk_s2 <= lastk_s1;
		prod_s2 <= 64'(a_rdata) * 64'(b_rdata);
		if (st_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
			i_q <= '0; j_q <= '0; k_q <= '0;
			acc_q <= '0;
			status <= cmd.err;
			last <= cmd.err;
			out_row <= '0; out_col <= '0; product_value <= '0;
		end
		if (st_q == ST_RUN) k_q <= k_end ? 3'd0 : 3'(k_q + 1'b1);
		if (v_s2) begin
			if (lastk_s2) begin
				product_value <= res;
				out_row <= i_q;
				out_col <= j_q;
				last <= i_q == cmd_q.lrows_m1 && j_q == cmd_q.rcols_m1;
				acc_q <= '0;
			end else begin
				acc_q <= sum;
			end
		end
		if (st_q == ST_OUT && out_ready && !last) begin
			if (j_q == cmd_q.rcols_m1) begin
				j_q <= '0; i_q <= 3'(i_q + 1'b1);
			end else begin
				j_q <= 3'(j_q + 1'b1);
			end
		end
	end

	assign out_valid = st_q == ST_OUT;
endmodule
`default_nettype wire

>>> src/matrix_multiply_transpose.sv
// Top level of the matrix multiply with optional operand transposes.
//  channel  | handshake              | payload
//  in       | valid / ready          | req_type, elem_index, elem_value
//  out      | out_valid / out_ready  | product_value, out_row, out_col, last, status
//  cfg      | cfg_we                 | cfg_idx, cfg_data
// Loads are accepted back to back. A start stalls the input from its acceptance until
// its last word is taken; each C element is a dot product run at one
// multiply-accumulate per cycle through a registered store read and product.
// An error start gives one word with status and last set, computing nothing. Output stalls
// freeze the sequencer. Reset restores register defaults; stores are not cleared.
`default_nettype none
module matrix_multiply_transpose import mmt_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [DIM_W-1:0]    cfg_data,
	input  wire logic                valid,
	output logic                     ready,
	input  wire logic [1:0]          req_type,
	input  wire logic [IDX_W-1:0]    elem_index,
	input  wire logic signed [VAL_W-1:0] elem_value,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [VAL_W-1:0]  product_value,
	output logic [2:0]               out_row,
	output logic [2:0]               out_col,
	output logic                     last,
	output logic                     status
);
	logic cmd_valid, cmd_ready;
	cmd_t cmd;
	logic [IDX_W-1:0] a_raddr, b_raddr;
	logic signed [VAL_W-1:0] a_rdata, b_rdata;

	mmt_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .valid, .ready,
		.req_type, .elem_index, .elem_value, .cmd_valid, .cmd_ready, .cmd,
		.a_raddr, .b_raddr, .a_rdata, .b_rdata
	);

	mmt_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .a_raddr, .b_raddr,
		.a_rdata, .b_rdata, .out_valid, .out_ready, .product_value,
		.out_row, .out_col, .last, .status
	);
endmodule
`default_nettype wire
